FILE: rtl/core/url_percent_decoder_utf8_core_assert.svh
// assertion macros for the core modules, used by the output queue
`ifndef URL_PERCENT_DECODER_UTF8_CORE_ASSERT_SVH
`define URL_PERCENT_DECODER_UTF8_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define UPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define UPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/upd_pkg.sv
`timescale 1ns / 1ps
package upd_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int FIELD_W         = 24;
  localparam int MAX_RESULTS     = 4;
  localparam int COUNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W           = $clog2(MAX_RESULTS);

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_OK         = 3'd1;
  localparam logic [2:0] KIND_BADCHAR    = 3'd2;
  localparam logic [2:0] KIND_BADSEQ     = 3'd3;
  localparam logic [2:0] KIND_INCOMPLETE = 3'd4;

  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LC_U  = 8'h75;
  localparam logic [7:0] CHAR_UC_U  = 8'h55;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic [2:0]         kind;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] position;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;
    logic [COUNT_W-1:0]        count;
  } group_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  // valid only for hex digits
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return c[6] ? (c[3:0] + 4'd9) : c[3:0];
  endfunction

endpackage

FILE: rtl/core/url_percent_decoder_utf8_core.sv
`timescale 1ns / 1ps
// url percent decoder with %uXXXX to utf-8
// input channel: in_valid/in_ready carry one source byte per word (in_byte,
// end_of_stream marks the last byte of a string)
// output channel: out_valid/out_ready carry one result word: a decoded byte
// or a status (done ok, bad character, bad sequence, incomplete), with the
// decoded length and source position; run_last flags the last word that one
// source byte caused
// a result is registered: it appears in the cycle after its byte is accepted
// throughput: one byte per cycle while out_ready is high and each byte
// yields at most one word; a byte with more (utf-8 expansion plus status)
// holds the input: the result register drains one word per ready cycle
// in_ready stays high while the last word of the current group is being taken
// reset clears the escape, discard and counter state and empties the result
// register; a stalled receiver holds the current word and in_ready drops
// once the queued group cannot be replaced
module url_percent_decoder_utf8_core #(
  parameter int LENGTH_BITS = upd_pkg::LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        end_of_stream,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  data_byte,
  output logic [2:0]                  result_kind,
  output logic [upd_pkg::FIELD_W-1:0] decoded_length,
  output logic [upd_pkg::FIELD_W-1:0] stop_position,
  output logic                        run_last
);
  import upd_pkg::*;

  group_t  group;
  result_t head;
  logic    accept;
  logic    take_ok;

  assign in_ready = take_ok;
  assign accept   = in_valid && take_ok;

  upd_decode #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (in_byte),
    .end_of_stream(end_of_stream),
    .group        (group)
  );

  upd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .group_in (group),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .take_ok  (take_ok),
    .head     (head),
    .head_last(run_last)
  );

  assign data_byte      = head.data_byte;
  assign result_kind    = head.kind;
  assign decoded_length = head.length;
  assign stop_position  = head.position;

endmodule

FILE: rtl/core/upd_decode.sv
`timescale 1ns / 1ps
module upd_decode #(
  parameter int LENGTH_BITS = upd_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            end_of_stream,
  output upd_pkg::group_t group
);
  import upd_pkg::*;

  localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] v,
                                                     input logic [1:0] k);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, v} + {{(LENGTH_BITS - 1){1'b0}}, k};
    return s[LENGTH_BITS] ? CNT_MAX : s[LENGTH_BITS-1:0];
  endfunction

  logic [7:0]             escape_chars [4];
  logic [2:0]             escape_count;
  logic                   discard_mode;
  logic [LENGTH_BITS-1:0] out_counter;
  logic [LENGTH_BITS-1:0] in_counter;
  logic [LENGTH_BITS-1:0] escape_start;

  logic [2:0]             escape_count_next;
  logic                   discard_mode_next;
  logic [LENGTH_BITS-1:0] out_counter_next;
  logic [LENGTH_BITS-1:0] in_counter_next;
  logic [LENGTH_BITS-1:0] escape_start_next;
  logic                   clear_all;
  logic                   chars_we;
  logic [1:0]             chars_idx;

  logic [LENGTH_BITS-1:0] in_inc;
  logic [LENGTH_BITS-1:0] len [4];
  logic [15:0]            code;
  logic [7:0]             dbyte [4];
  logic [1:0]             ndata;
  logic                   err_flag;
  logic [2:0]             err_kind;
  logic [LENGTH_BITS-1:0] err_pos;
  logic                   status_flag;
  logic [2:0]             status_kind;
  logic [LENGTH_BITS-1:0] status_pos;

  assign in_inc    = sat_add(in_counter, 2'd1);
  assign chars_idx = 2'(escape_count - 3'd1);
  assign code      = {hex_val(escape_chars[1]), hex_val(escape_chars[2]),
                      hex_val(escape_chars[3]), hex_val(in_byte)};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      len[k] = sat_add(out_counter, 2'(k));
    end
  end

  always_comb begin
    ndata             = 2'd0;
    dbyte[0]          = 8'h00;
    dbyte[1]          = 8'h00;
    dbyte[2]          = 8'h00;
    dbyte[3]          = 8'h00;
    err_flag          = 1'b0;
    err_kind          = KIND_BADSEQ;
    err_pos           = in_counter;
    status_flag       = 1'b0;
    status_kind       = KIND_OK;
    status_pos        = in_inc;
    escape_count_next = escape_count;
    escape_start_next = escape_start;
    discard_mode_next = discard_mode;
    in_counter_next   = in_counter;
    clear_all         = 1'b0;
    chars_we          = 1'b0;
    if (discard_mode) begin
      clear_all = end_of_stream;
    end else begin
      in_counter_next = in_inc;
      if (escape_count == 3'd0) begin
        if (in_byte == CHAR_PLUS) begin
          ndata    = 2'd1;
          dbyte[0] = CHAR_SPACE;
        end else if (in_byte == CHAR_PCT) begin
          escape_count_next = 3'd1;
          escape_start_next = in_counter;
        end else if (in_byte == 8'h00) begin
          err_flag = 1'b1;
          err_kind = KIND_BADCHAR;
          err_pos  = in_counter;
        end else begin
          ndata    = 2'd1;
          dbyte[0] = in_byte;
        end
      end else begin
        chars_we          = (escape_count <= 3'd4);
        escape_count_next = escape_count + 3'd1;
        if (escape_count == 3'd2) begin
          if (is_hex(escape_chars[0]) && is_hex(in_byte)) begin
            ndata             = 2'd1;
            dbyte[0]          = {hex_val(escape_chars[0]), hex_val(in_byte)};
            escape_count_next = 3'd0;
          end else if (escape_chars[0] != CHAR_LC_U && escape_chars[0] != CHAR_UC_U) begin
            err_flag          = 1'b1;
            err_pos           = escape_start;
            escape_count_next = 3'd0;
          end
        end else if (escape_count == 3'd5) begin
          if (is_hex(escape_chars[1]) && is_hex(escape_chars[2]) &&
              is_hex(escape_chars[3]) && is_hex(in_byte)) begin
            if (code < 16'h0080) begin
              ndata    = 2'd1;
              dbyte[0] = code[7:0];
            end else if (code < 16'h0800) begin
              ndata    = 2'd2;
              dbyte[0] = {3'b110, code[10:6]};
              dbyte[1] = {2'b10, code[5:0]};
            end else begin
              ndata    = 2'd3;
              dbyte[0] = {4'b1110, code[15:12]};
              dbyte[1] = {2'b10, code[11:6]};
              dbyte[2] = {2'b10, code[5:0]};
            end
          end else begin
            err_flag = 1'b1;
            err_pos  = escape_start;
          end
          escape_count_next = 3'd0;
        end
      end
      if (err_flag) begin
        status_flag = 1'b1;
        status_kind = err_kind;
        status_pos  = err_pos;
        if (end_of_stream) begin
          clear_all = 1'b1;
        end else begin
          discard_mode_next = 1'b1;
        end
      end else if (end_of_stream) begin
        status_flag = 1'b1;
        clear_all   = 1'b1;
        if (escape_count_next != 3'd0) begin
          status_kind = KIND_INCOMPLETE;
          status_pos  = escape_start_next;
        end
      end
    end
    out_counter_next = len[ndata];
  end

  // results in order: data bytes, then the status word if any
  always_comb begin
    group.count = COUNT_W'(ndata) + COUNT_W'(status_flag);
    for (int i = 0; i < MAX_RESULTS; i++) begin
      group.res[i] = '0;
      if (2'(i) < ndata) begin
        group.res[i].data_byte = dbyte[i];
        group.res[i].kind      = KIND_DATA;
        group.res[i].length    = FIELD_W'(len[2'(i + 1)]);
        group.res[i].position  = FIELD_W'(in_counter);
      end else if (2'(i) == ndata && status_flag) begin
        group.res[i].kind      = status_kind;
        group.res[i].length    = FIELD_W'(len[ndata]);
        group.res[i].position  = FIELD_W'(status_pos);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_count <= 3'd0;
      discard_mode <= 1'b0;
      out_counter  <= '0;
      in_counter   <= '0;
      escape_start <= '0;
    end else if (accept) begin
      if (clear_all) begin
        escape_count <= 3'd0;
        discard_mode <= 1'b0;
        out_counter  <= '0;
        in_counter   <= '0;
        escape_start <= '0;
      end else begin
        escape_count <= escape_count_next;
        discard_mode <= discard_mode_next;
        out_counter  <= out_counter_next;
        in_counter   <= in_counter_next;
        escape_start <= escape_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && chars_we) begin
      escape_chars[chars_idx] <= in_byte;
    end
  end

endmodule

FILE: rtl/core/upd_outq.sv
`timescale 1ns / 1ps
`include "url_percent_decoder_utf8_core_assert.svh"
module upd_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  upd_pkg::group_t  group_in,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             take_ok,
  output upd_pkg::result_t head,
  output logic             head_last
);
  import upd_pkg::*;

  group_t             grp;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]   idx;
  logic               busy;

  assign busy      = (count != '0);
  assign head_last = busy && (COUNT_W'(idx) == count - COUNT_W'(1));
  assign take_ok   = !busy || (head_last && out_ready);
  assign out_valid = busy;
  assign head      = grp.res[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (load) begin
      count <= group_in.count;
      idx   <= '0;
    end else if (busy && out_ready) begin
      if (head_last) begin
        count <= '0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= group_in;
    end
  end

  `UPD_ASSERT(a_idx_in_range, !busy || (COUNT_W'(idx) < count), "result index past group end")
  `UPD_ASSERT_NEXT(a_hold_on_stall, busy && !out_ready, (count == $past(count)) && (idx == $past(idx)), "result moved while stalled")
  `UPD_ASSERT_NEXT(a_step_next, busy && out_ready && !head_last, idx == $past(idx) + IDX_W'(1), "result skipped in group")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import upd_pkg::*;

  localparam int RANDOM_WORDS = 140;
  localparam int CALM_AFTER   = 115;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_CAP   = 30;

  localparam logic [7:0] CHAR_NUL = 8'h00;

  typedef struct {
    logic [7:0]         data;
    logic [2:0]         kind;
    logic [FIELD_W-1:0] len;
    logic [FIELD_W-1:0] pos;
    logic               last;
  } dec_word_t;

  class decode_tracker;
    logic [7:0]         esc_bytes[5];
    int                 esc_len;
    bit                 dropping;
    logic [FIELD_W-1:0] out_count;
    logic [FIELD_W-1:0] in_count;
    logic [FIELD_W-1:0] esc_origin;
    dec_word_t          pending_words[$];
    dec_word_t          burst[$];
    int                 mismatches;
    int                 taken;

    function new();
      foreach (esc_bytes[i]) esc_bytes[i] = 8'h00;
      mismatches = 0;
      taken = 0;
      clear_stream();
    endfunction

    static function bit hex_ok(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    static function logic [3:0] nibble(logic [7:0] c);
      logic [7:0] v;
      if (c >= "a") v = c - "a" + 8'd10;
      else if (c >= "A") v = c - "A" + 8'd10;
      else v = c - "0";
      return v[3:0];
    endfunction

    function logic [FIELD_W-1:0] bump(logic [FIELD_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void clear_stream();
      esc_len = 0;
      dropping = 0;
      out_count = '0;
      in_count = '0;
      esc_origin = '0;
    endfunction

    function void emit(logic [7:0] d, logic [2:0] k, logic [FIELD_W-1:0] p);
      dec_word_t w;
      if (k == KIND_DATA) out_count = bump(out_count);
      w.data = d;
      w.kind = k;
      w.len = out_count;
      w.pos = p;
      w.last = 1'b0;
      burst.push_back(w);
    endfunction

    function bit note_input(logic [7:0] b, logic eos);
      bit                 fault;
      logic [2:0]         err;
      logic [FIELD_W-1:0] cur;
      logic [FIELD_W-1:0] err_pos;
      logic [7:0]         c1;
      logic [15:0]        cp;
      fault = 0;
      err = KIND_BADCHAR;
      err_pos = '0;
      taken++;
      if (dropping) begin
        if (eos) clear_stream();
        return 0;
      end
      burst.delete();
      cur = in_count;
      in_count = bump(in_count);
      if (esc_len == 0) begin
        if (b == CHAR_PLUS) begin
          emit(CHAR_SPACE, KIND_DATA, cur);
        end else if (b == CHAR_PCT) begin
          esc_len = 1;
          esc_origin = cur;
        end else if (b == CHAR_NUL) begin
          fault = 1;
          err = KIND_BADCHAR;
          err_pos = cur;
        end else begin
          emit(b, KIND_DATA, cur);
        end
      end else begin
        esc_bytes[esc_len - 1] = b;
        esc_len++;
        c1 = esc_bytes[0];
        if (esc_len == 3) begin
          if (hex_ok(c1) && hex_ok(esc_bytes[1])) begin
            emit({nibble(c1), nibble(esc_bytes[1])}, KIND_DATA, cur);
            esc_len = 0;
          end else if (c1 != CHAR_LC_U && c1 != CHAR_UC_U) begin
            fault = 1;
            err = KIND_BADSEQ;
            err_pos = esc_origin;
            esc_len = 0;
          end
        end else if (esc_len == 6) begin
          if (hex_ok(esc_bytes[1]) && hex_ok(esc_bytes[2]) &&
              hex_ok(esc_bytes[3]) && hex_ok(esc_bytes[4])) begin
            cp = {nibble(esc_bytes[1]), nibble(esc_bytes[2]),
                  nibble(esc_bytes[3]), nibble(esc_bytes[4])};
            if (cp < 16'h0080) begin
              emit(cp[7:0], KIND_DATA, cur);
            end else if (cp < 16'h0800) begin
              emit({3'b110, cp[10:6]}, KIND_DATA, cur);
              emit({2'b10, cp[5:0]}, KIND_DATA, cur);
            end else begin
              emit({4'b1110, cp[15:12]}, KIND_DATA, cur);
              emit({2'b10, cp[11:6]}, KIND_DATA, cur);
              emit({2'b10, cp[5:0]}, KIND_DATA, cur);
            end
          end else begin
            fault = 1;
            err = KIND_BADSEQ;
            err_pos = esc_origin;
          end
          esc_len = 0;
        end
      end
      if (fault) begin
        emit(8'h00, err, err_pos);
        if (eos) clear_stream();
        else dropping = 1;
      end else if (eos) begin
        if (esc_len != 0) emit(8'h00, KIND_INCOMPLETE, esc_origin);
        else emit(8'h00, KIND_OK, in_count);
        clear_stream();
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_words.push_back(burst[i]);
      return 1;
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction

    task report(string msg);
      if (mismatches < REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic [7:0] d, logic [2:0] k, logic [FIELD_W-1:0] len,
                    logic [FIELD_W-1:0] pos, logic last);
      dec_word_t w;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d data %02h pos %0d", k, d, pos));
        return;
      end
      w = pending_words.pop_front();
      if (d !== w.data)
        report($sformatf("data_byte %02h, want %02h (pos %0d)", d, w.data, w.pos));
      if (k !== w.kind)
        report($sformatf("result_kind %0d, want %0d (pos %0d)", k, w.kind, w.pos));
      if (len !== w.len)
        report($sformatf("decoded_length %0d, want %0d (pos %0d)", len, w.len, w.pos));
      if (pos !== w.pos)
        report($sformatf("stop_position %0d, want %0d", pos, w.pos));
      if (last !== w.last)
        report($sformatf("run_last %b, want %b (pos %0d)", last, w.last, w.pos));
    endtask

    task flush_leftovers();
      while (pending_words.size() > 0) begin
        report($sformatf("missing word kind %0d pos %0d",
                         pending_words[0].kind, pending_words[0].pos));
        void'(pending_words.pop_front());
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic end_of_stream = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [7:0] data_byte;
  logic [2:0] result_kind;
  logic [FIELD_W-1:0] decoded_length;
  logic [FIELD_W-1:0] stop_position;
  logic run_last;

  decode_tracker tracker;
  logic [7:0] stream_q[$];
  int cycle_count = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  url_percent_decoder_utf8_core DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_stream  (end_of_stream),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .data_byte      (data_byte),
    .result_kind    (result_kind),
    .decoded_length (decoded_length),
    .stop_position  (stop_position),
    .run_last       (run_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) void'(tracker.note_input(in_byte, end_of_stream));
      if (out_valid && out_ready)
        tracker.check_word(data_byte, result_kind, decoded_length, stop_position, run_last);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // receiver side: random stall bursts, one long hold-off once the random phase starts, no stalls when calm
  initial begin
    bit hold_done;
    hold_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1;
      end else if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
  endfunction

  task automatic send_byte(logic [7:0] b, logic eos);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    end_of_stream <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(string s, logic eos);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], eos && (i == s.len() - 1));
  endtask

  initial begin
    int base;
    int pick;
    int slot;
    logic [7:0] v;
    logic [15:0] cp;
    logic [7:0] digs[4];
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // one-, two- and three-byte utf-8 extremes, four words on the last byte, a NUL error, then an open escape
    send_text("+%4a%u007F%U07fF%uFFFf", 1'b1);
    send_byte(CHAR_NUL, 1'b1);
    send_byte(CHAR_PCT, 1'b0);
    send_byte(CHAR_NUL, 1'b1);
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);

    base = tracker.taken;
    hold_req = 1'b1;
    while (tracker.taken - base < RANDOM_WORDS) begin
      calm = (tracker.taken - base) >= CALM_AFTER;
      stream_q.delete();
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          do v = 8'($urandom_range(1, 255)); while (v == CHAR_PCT || v == CHAR_PLUS);
          stream_q.push_back(v);
        end else if (pick < 40) begin
          stream_q.push_back(CHAR_PLUS);
        end else if (pick < 58) begin
          v = 8'($urandom_range(0, 255));
          stream_q.push_back(CHAR_PCT);
          stream_q.push_back(hex_char(v[7:4]));
          stream_q.push_back(hex_char(v[3:0]));
        end else if (pick < 90 && pick >= 80) begin
          stream_q.push_back((pick < 87) ? 8'($urandom_range(0, 255)) : CHAR_NUL);
        end else if (pick < 95 && pick >= 90) begin
          stream_q.push_back(CHAR_PCT);
          stream_q.push_back(8'($urandom_range(0, 255)));
          stream_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 2))
            0: cp = 16'($urandom_range(16'h0000, 16'h007f));
            1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
            default: cp = 16'($urandom_range(16'h0800, 16'hffff));
          endcase
          digs[0] = hex_char(cp[15:12]);
          digs[1] = hex_char(cp[11:8]);
          digs[2] = hex_char(cp[7:4]);
          digs[3] = hex_char(cp[3:0]);
          if (pick >= 95) begin
            // one non-hex digit in the %u window
            case ($urandom_range(0, 3))
              0: v = 8'($urandom_range(8'h00, 8'h2f));
              1: v = 8'($urandom_range(8'h3a, 8'h40));
              2: v = 8'($urandom_range(8'h47, 8'h60));
              default: v = 8'($urandom_range(8'h67, 8'hff));
            endcase
            slot = $urandom_range(0, 3);
            digs[slot] = v;
          end
          stream_q.push_back(CHAR_PCT);
          stream_q.push_back($urandom_range(0, 1) ? CHAR_LC_U : CHAR_UC_U);
          foreach (digs[i]) stream_q.push_back(digs[i]);
        end
      end
      // escape left open at end of stream
      if ($urandom_range(0, 7) == 0) begin
        stream_q.push_back(CHAR_PCT);
        case ($urandom_range(0, 2))
          0: ;
          1: stream_q.push_back(hex_char(4'($urandom_range(0, 15))));
          default: begin
            stream_q.push_back($urandom_range(0, 1) ? CHAR_LC_U : CHAR_UC_U);
            repeat ($urandom_range(0, 3))
              stream_q.push_back(hex_char(4'($urandom_range(0, 15))));
          end
        endcase
      end
      foreach (stream_q[i]) send_byte(stream_q[i], i == stream_q.size() - 1);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (tracker.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.flush_leftovers();
    if (tracker.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
